FILE: rtl/bgd_pkg.sv
// Package for the binary grid dilation unit.
// Holds the grid geometry, field widths, shared types and the row mask.
// No dependencies.
package bgd_pkg;

  localparam int GRID_ROWS  = 1024;
  localparam int GRID_COLS  = 64;
  localparam int MAX_RADIUS = 8;
  localparam int HIST_DEPTH = 2 * MAX_RADIUS + 1;

  localparam int ROW_W = 64;
  localparam int IDX_W = 10;
  localparam int RAD_W = 4;
  localparam int AGE_W = $clog2(HIST_DEPTH);

  typedef logic [ROW_W-1:0] row_t;
  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [RAD_W-1:0] rad_t;
  typedef logic [AGE_W-1:0] age_t;
  typedef logic [HIST_DEPTH-1:0][ROW_W-1:0] hist_t;

  localparam rad_t RESET_RADIUS = rad_t'(1);
  localparam rad_t RADIUS_LIMIT = rad_t'(MAX_RADIUS);
  localparam idx_t LAST_ROW     = idx_t'(GRID_ROWS - 1);

  // Columns that exist in the grid
  localparam row_t COL_MASK = (GRID_COLS >= ROW_W) ? {ROW_W{1'b1}}
                                                   : ((row_t'(1) << GRID_COLS) - row_t'(1));

  // One output row to build: its index, the newest row held, and the radius
  typedef struct packed {
    idx_t row_k;
    idx_t newest;
    rad_t radius;
  } job_t;

endpackage

FILE: rtl/bgd_dilate.sv
// Row builder for the binary grid dilation unit: vertical OR over the
// clipped window of held rows, then horizontal widening. Uses bgd_pkg.
module bgd_dilate (
  input  bgd_pkg::hist_t hist_i,
  input  bgd_pkg::job_t  job_i,
  output bgd_pkg::row_t  row_o
);

  logic [bgd_pkg::IDX_W:0] top_j;
  logic [bgd_pkg::IDX_W:0] sum_j;
  bgd_pkg::idx_t           hi_j;
  bgd_pkg::idx_t           lo_j;
  bgd_pkg::idx_t           age_lo_w;
  bgd_pkg::idx_t           age_hi_w;
  bgd_pkg::age_t           age_lo;
  bgd_pkg::age_t           age_hi;
  bgd_pkg::row_t           vrow;
  bgd_pkg::row_t           wrow;

  // Clip the window to rows 0 .. newest and turn it into an age range
  always_comb begin
    sum_j = {1'b0, job_i.row_k} + {{(bgd_pkg::IDX_W + 1 - bgd_pkg::RAD_W){1'b0}}, job_i.radius};
    top_j = {1'b0, job_i.newest};
    hi_j  = (sum_j > top_j) ? job_i.newest : sum_j[bgd_pkg::IDX_W-1:0];
    lo_j  = (job_i.row_k >= bgd_pkg::idx_t'(job_i.radius))
            ? (job_i.row_k - bgd_pkg::idx_t'(job_i.radius)) : '0;
    age_lo_w = job_i.newest - hi_j;
    age_hi_w = job_i.newest - lo_j;
    age_lo   = age_lo_w[bgd_pkg::AGE_W-1:0];
    age_hi   = age_hi_w[bgd_pkg::AGE_W-1:0];
  end

  // OR the held rows whose age falls inside the window
  always_comb begin
    vrow = '0;
    for (int a = 0; a < bgd_pkg::HIST_DEPTH; a++) begin
      if ((bgd_pkg::age_t'(a) >= age_lo) && (bgd_pkg::age_t'(a) <= age_hi)) begin
        vrow = vrow | hist_i[a];
      end
    end
  end

  // Widen the row sideways by the radius
  always_comb begin
    wrow = vrow;
    for (int d = 1; d <= bgd_pkg::MAX_RADIUS; d++) begin
      if (bgd_pkg::rad_t'(d) <= job_i.radius) begin
        wrow = wrow | (vrow << d) | (vrow >> d);
      end
    end
  end

  assign row_o = wrow & bgd_pkg::COL_MASK;

endmodule

FILE: rtl/binary_grid_dilation_square_unit.sv
// Top level of the binary grid dilation unit: row history, emit sequencer
// and a two-word result queue. Uses bgd_pkg and bgd_dilate.
//
//   channel | direction | handshake               | word
//   --------+-----------+-------------------------+------------------------------
//   in      | input     | in_valid_i / in_stall_o | row_cells_i
//   out     | output    | out_valid_o/out_stall_i | padded_row_o, out_row_index_o,
//           |           |                         | frame_done_o
//   cfg     | input     | cfg_we_i                | cfg_wdata_i (pad radius)
//
// One row word is taken per cycle unless in_stall_o holds it; each row word but
// the last of a grid yields at most one result, built from the job registers
// loaded when it is taken and written into the result queue once the queue has room.
// The last row of a grid makes the emit sequencer flush radius+1 rows, one
// flushed row per cycle while the queue has room; no input word is taken before
// the final flush row is written, and the next row word can be taken in that cycle.
// in_stall_o comes from registers only; the two-word queue absorbs a stall.
// Reset clears the history, the row count and the queue, and sets radius 1.
module binary_grid_dilation_square_unit (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  bgd_pkg::row_t         row_cells_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output bgd_pkg::row_t         padded_row_o,
  output bgd_pkg::idx_t         out_row_index_o,
  output logic                  frame_done_o,
  input  logic                  cfg_we_i,
  input  bgd_pkg::rad_t         cfg_wdata_i
);

  bgd_pkg::rad_t  radius_q;
  bgd_pkg::rad_t  radius_sat;
  bgd_pkg::hist_t hist_q, hist_d, hist_base;
  bgd_pkg::idx_t  rows_q, rows_d;
  logic           job_valid_q, job_valid_d;
  logic           job_final_q, job_final_d;
  bgd_pkg::idx_t  job_k_q, job_k_d;
  bgd_pkg::idx_t  job_newest_q, job_newest_d;
  bgd_pkg::job_t  job;
  bgd_pkg::row_t  built_row;
  logic           job_adv, job_more, job_done, clear_hist, in_acc;

  bgd_pkg::row_t  qrow_q [2];
  bgd_pkg::idx_t  qidx_q [2];
  logic           qdone_q [2];
  logic [1:0]     qcnt_q, qcnt_d;
  logic           wptr_q, rptr_q;
  logic           push, pop;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= bgd_pkg::RESET_RADIUS;
    end else if (cfg_we_i) begin
      radius_q <= cfg_wdata_i;
    end
  end

  assign radius_sat = (radius_q > bgd_pkg::RADIUS_LIMIT) ? bgd_pkg::RADIUS_LIMIT : radius_q;

  // Sequencer handshake: advance when the queue has room
  assign job_adv    = job_valid_q && (qcnt_q != 2'd2);
  assign job_more   = job_final_q && (job_k_q != bgd_pkg::LAST_ROW);
  assign job_done   = job_adv && !job_more;
  assign clear_hist = job_done && job_final_q;
  assign in_stall_o = job_valid_q && !job_done;
  assign in_acc     = in_valid_i && !in_stall_o;

  // Shift the new row into the history; drop it all at grid end
  always_comb begin
    hist_base = clear_hist ? '0 : hist_q;
    hist_d    = in_acc ? {hist_base[bgd_pkg::HIST_DEPTH-2:0], row_cells_i & bgd_pkg::COL_MASK}
                       : hist_base;
    rows_d    = rows_q;
    if (in_acc) begin
      rows_d = (rows_q == bgd_pkg::LAST_ROW) ? '0 : rows_q + bgd_pkg::idx_t'(1);
    end
  end

  // Load a job on each row word, step through the flush on the last one
  always_comb begin
    job_valid_d  = job_valid_q;
    job_final_d  = job_final_q;
    job_k_d      = job_k_q;
    job_newest_d = job_newest_q;
    if (job_adv) begin
      if (job_more) begin
        job_k_d = job_k_q + bgd_pkg::idx_t'(1);
      end else begin
        job_valid_d = 1'b0;
      end
    end
    if (in_acc) begin
      job_valid_d  = (rows_q >= bgd_pkg::idx_t'(radius_sat));
      job_final_d  = (rows_q == bgd_pkg::LAST_ROW);
      job_k_d      = rows_q - bgd_pkg::idx_t'(radius_sat);
      job_newest_d = rows_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q      <= '0;
      rows_q      <= '0;
      job_valid_q <= 1'b0;
      job_final_q <= 1'b0;
    end else begin
      hist_q      <= hist_d;
      rows_q      <= rows_d;
      job_valid_q <= job_valid_d;
      job_final_q <= job_final_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_k_q      <= job_k_d;
    job_newest_q <= job_newest_d;
  end

  // Build the current row from the history
  assign job = '{row_k: job_k_q, newest: job_newest_q, radius: radius_sat};

  bgd_dilate u_dilate (
    .hist_i (hist_q),
    .job_i  (job),
    .row_o  (built_row)
  );

  // Result queue, two words deep
  assign push = job_adv;
  assign pop  = out_valid_o && !out_stall_i;

  always_comb begin
    qcnt_d = qcnt_q;
    case ({push, pop})
      2'b10:   qcnt_d = qcnt_q + 2'd1;
      2'b01:   qcnt_d = qcnt_q - 2'd1;
      default: qcnt_d = qcnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qcnt_q <= '0;
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
    end else begin
      qcnt_q <= qcnt_d;
      if (push) begin
        wptr_q <= !wptr_q;
      end
      if (pop) begin
        rptr_q <= !rptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      qrow_q[wptr_q]  <= built_row;
      qidx_q[wptr_q]  <= job_k_q;
      qdone_q[wptr_q] <= (job_k_q == bgd_pkg::LAST_ROW);
    end
  end

  assign out_valid_o     = (qcnt_q != 2'd0);
  assign padded_row_o    = qrow_q[rptr_q];
  assign out_row_index_o = qidx_q[rptr_q];
  assign frame_done_o    = qdone_q[rptr_q];

endmodule
